@@ sv/hdu_pkg.sv @@
// ----------------------------------------------------------------------------
// hdu_pkg: shared types and constants
// Phase codes, state and result records, and the fixed field widths of the
// half-duplex 8N1 transceiver.
// ----------------------------------------------------------------------------
package hdu_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 4;

  // Bit index values that mark the data bits and the two tail slots.
  localparam logic [BitIdxW-1:0] BitIdxFirst = BitIdxW'(0);
  localparam logic [BitIdxW-1:0] BitIdxData  = BitIdxW'(ByteW);      // all data bits done
  localparam logic [BitIdxW-1:0] BitIdxStop  = BitIdxW'(ByteW + 1);  // in stop slot

  localparam logic [CntW-1:0] BitPeriodRst = 16'd416;
  localparam logic [CntW-1:0] StartWaitRst = 16'd624;

  // Register indexes of the configuration port.
  localparam logic CfgBitPeriod = 1'b0;
  localparam logic CfgStartWait = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RX   = 2'd1,
    PH_TX   = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [CntW-1:0]     cycle_count;
    logic [BitIdxW-1:0]  bit_index;
    logic [ByteW-1:0]    shift_reg;
    logic                line_out;
    logic [ByteW-1:0]    held_rx_byte;
  } uart_state_t;

  typedef struct packed {
    logic [CntW-1:0] bit_period;
    logic [CntW-1:0] start_wait;
  } uart_cfg_t;

  typedef struct packed {
    logic             rx_line;
    logic             send_go;
    logic [ByteW-1:0] send_byte;
  } uart_in_t;

  typedef struct packed {
    logic             tx_line;
    logic [ByteW-1:0] rx_byte;
    logic             rx_done;
    logic             tx_done;
    logic             busy_res;
  } uart_res_t;

endpackage

@@ sv/hdu_step.sv @@
// ----------------------------------------------------------------------------
// hdu_step: combinational transceiver update
// Computes the next state and the result for one line sample / send request.
// ----------------------------------------------------------------------------
module hdu_step (
  input  hdu_pkg::uart_state_t cur_i,
  input  hdu_pkg::uart_cfg_t   cfg_i,
  input  hdu_pkg::uart_in_t    in_i,
  output hdu_pkg::uart_state_t nxt_o,
  output hdu_pkg::uart_res_t   res_o
);

  logic [hdu_pkg::CntW-1:0] cnt_inc;
  logic [hdu_pkg::CntW-1:0] limit;
  logic                     tick;
  logic                     rx_done;
  logic                     tx_done;

  assign cnt_inc = cur_i.cycle_count + hdu_pkg::CntW'(1);
  assign limit   = (cur_i.phase == hdu_pkg::PH_RX && cur_i.bit_index == hdu_pkg::BitIdxFirst)
                   ? cfg_i.start_wait : cfg_i.bit_period;
  // Wrap of the counter counts as a tick, so a zero limit ticks every cycle.
  assign tick    = (cnt_inc >= limit) || (cnt_inc == '0);

  always_comb begin
    nxt_o   = cur_i;
    rx_done = 1'b0;
    tx_done = 1'b0;
    unique case (cur_i.phase)
      hdu_pkg::PH_RX: begin
        nxt_o.cycle_count = tick ? '0 : cnt_inc;
        if (cur_i.bit_index < hdu_pkg::BitIdxData) begin
          if (tick) begin
            nxt_o.shift_reg = {in_i.rx_line, cur_i.shift_reg[hdu_pkg::ByteW-1:1]};
            nxt_o.bit_index = cur_i.bit_index + hdu_pkg::BitIdxW'(1);
          end
        end else if (cur_i.bit_index == hdu_pkg::BitIdxData) begin
          if (tick) begin
            nxt_o.bit_index = hdu_pkg::BitIdxStop;
          end
        end else if (in_i.rx_line || tick) begin
          // Stop wait ends early on a high line.
          nxt_o.held_rx_byte = cur_i.shift_reg;
          rx_done            = 1'b1;
          nxt_o.phase        = hdu_pkg::PH_IDLE;
          nxt_o.cycle_count  = '0;
          nxt_o.bit_index    = hdu_pkg::BitIdxFirst;
        end
      end
      hdu_pkg::PH_TX: begin
        nxt_o.cycle_count = tick ? '0 : cnt_inc;
        if (tick) begin
          if (cur_i.bit_index < hdu_pkg::BitIdxData) begin
            nxt_o.line_out  = cur_i.shift_reg[0];
            nxt_o.shift_reg = {1'b0, cur_i.shift_reg[hdu_pkg::ByteW-1:1]};
            nxt_o.bit_index = cur_i.bit_index + hdu_pkg::BitIdxW'(1);
          end else if (cur_i.bit_index == hdu_pkg::BitIdxData) begin
            nxt_o.line_out  = 1'b1;
            nxt_o.bit_index = hdu_pkg::BitIdxStop;
          end else begin
            nxt_o.line_out  = 1'b1;
            tx_done         = 1'b1;
            nxt_o.phase     = hdu_pkg::PH_IDLE;
            nxt_o.bit_index = hdu_pkg::BitIdxFirst;
          end
        end
      end
      default: begin
        // Idle, and the unused code behaves as idle; a low line wins over send.
        nxt_o.phase    = hdu_pkg::PH_IDLE;
        nxt_o.line_out = 1'b1;
        if (!in_i.rx_line) begin
          nxt_o.phase       = hdu_pkg::PH_RX;
          nxt_o.cycle_count = '0;
          nxt_o.bit_index   = hdu_pkg::BitIdxFirst;
          nxt_o.shift_reg   = '0;
        end else if (in_i.send_go) begin
          nxt_o.phase       = hdu_pkg::PH_TX;
          nxt_o.cycle_count = '0;
          nxt_o.bit_index   = hdu_pkg::BitIdxFirst;
          nxt_o.shift_reg   = in_i.send_byte;
          nxt_o.line_out    = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    res_o.tx_line  = nxt_o.line_out;
    res_o.rx_byte  = nxt_o.held_rx_byte;
    res_o.rx_done  = rx_done;
    res_o.tx_done  = tx_done;
    res_o.busy_res = (nxt_o.phase != hdu_pkg::PH_IDLE);
  end

endmodule

@@ sv/half_duplex_uart_8n1.sv @@
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1: half-duplex 8N1 UART transceiver
// Cycle-stepped receiver and transmitter sharing one bit timer and shift reg.
// ----------------------------------------------------------------------------
// Each input request is one clock of the serial world: it carries the receive
// pin level and an optional send request with a byte. Every request yields
// exactly one result (transmit pin level, last received byte, done strobes and
// busy). The block takes one request per cycle while the output register is empty
// or being drained: the transceiver state updates in the accepting cycle through a
// single combinational step, and the result goes into an output register, so a new
// request is taken while a result still waits as long as the downstream side takes
// it in the same cycle. Throughput is limited only by downstream backpressure.
// Reception starts on a low line while idle; the first data sample comes
// start_wait requests after that, then one every bit_period. Sending while
// busy is ignored. Write configuration only while idle.
module half_duplex_uart_8n1 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] rx_line, [1] send_go, [9:2] send_byte, rest 0
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] tx_line, [8:1] rx_byte, [9] rx_done,
                                      // [10] tx_done, [11] busy_res, rest 0
);

  hdu_pkg::uart_cfg_t   cfg_q;
  hdu_pkg::uart_state_t state_q, state_d;
  hdu_pkg::uart_res_t   res_q, res_d;
  hdu_pkg::uart_in_t    req;
  logic                 out_valid_q;
  logic                 in_fire;

  // Accept while the output slot is empty or being drained this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign req.rx_line   = s_axis_tdata[0];
  assign req.send_go   = s_axis_tdata[1];
  assign req.send_byte = s_axis_tdata[9:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period <= hdu_pkg::BitPeriodRst;
      cfg_q.start_wait <= hdu_pkg::StartWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        hdu_pkg::CfgBitPeriod: cfg_q.bit_period <= cfg_wdata_i;
        hdu_pkg::CfgStartWait: cfg_q.start_wait <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hdu_step u_step (
    .cur_i (state_q),
    .cfg_i (cfg_q),
    .in_i  (req),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  // Advance the transceiver only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= hdu_pkg::PH_IDLE;
      state_q.cycle_count  <= '0;
      state_q.bit_index    <= '0;
      state_q.shift_reg    <= '0;
      state_q.line_out     <= 1'b1;
      state_q.held_rx_byte <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.busy_res, res_q.tx_done, res_q.rx_done,
                          res_q.rx_byte, res_q.tx_line};

  // An idle transceiver always sits at the first bit slot.
  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == hdu_pkg::PH_IDLE) |-> (state_q.bit_index == hdu_pkg::BitIdxFirst))
    else $error("idle with nonzero bit index");

  // The pin only leaves the idle level while transmitting.
  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != hdu_pkg::PH_TX) |-> state_q.line_out)
    else $error("tx line low outside transmission");

  // Half duplex: at most one completion per result, and never while busy.
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.rx_done && res_q.tx_done)
                    && !((res_q.rx_done || res_q.tx_done) && res_q.busy_res))
    else $error("conflicting completion flags");

  // Bit index never runs past the stop slot.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_index <= hdu_pkg::BitIdxStop)
    else $error("bit index out of range");

  // State holds when no request is accepted.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state moved without a request");

endmodule

@@ sim/half_duplex_uart_8n1_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_test: request/result testbench for the 8N1 transceiver
// Streams one request per serial clock (receive level, send request, byte)
// into the block and predicts every result cycle by cycle with a local model
// of the transceiver. Directed frames cover the idle outputs after reset, both
// data extremes, broken stop bits, send collisions and the minimum and zero
// bit timings. Random frames with noise run under several bit timings.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_test;

  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned QueueDepth = 32;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_addr_i    = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [0] rx_line, [1] send_go, [9:2] send_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] tx_line, [8:1] rx_byte, [9] rx_done,
                                     // [10] tx_done, [11] busy_res

  half_duplex_uart_8n1 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Requests waiting to be offered, and the outputs each accepted request owes.
  logic [15:0]        serial_reqs[$];
  hdu_pkg::uart_res_t uart_outputs_due[$];

  int unsigned error_count    = 0;
  int unsigned items_pushed   = 0;
  int unsigned elapsed_cycles = 0;

  // Handshake pacing. quiet turns off idling on both sides; hold_arm asks the
  // result side for one long hold-off.
  logic        req_taken  = 1'b0;
  bit          quiet      = 1'b0;
  bit          hold_arm   = 1'b0;
  bit          hold_used  = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  // Local copy of the transceiver: configuration and state, reset values.
  logic [15:0]      m_bit_period = hdu_pkg::BitPeriodRst;
  logic [15:0]      m_start_wait = hdu_pkg::StartWaitRst;
  hdu_pkg::phase_e  m_phase      = hdu_pkg::PH_IDLE;
  logic [15:0]      m_count      = '0;
  logic [3:0]       m_bit_idx    = '0;
  logic [7:0]       m_shift      = '0;
  logic             m_line       = 1'b1;
  logic [7:0]       m_rx_byte    = '0;

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Advance the bit timer; report a tick when it reaches the limit or wraps.
  function automatic bit timer_hit(logic [15:0] limit);
    logic [15:0] nxt;
    nxt = m_count + 16'd1;
    if (nxt >= limit || nxt == 16'd0) begin
      m_count = '0;
      return 1'b1;
    end
    m_count = nxt;
    return 1'b0;
  endfunction

  // One serial clock of the transceiver: update state, return the outputs.
  task automatic uart_step(input logic rx, input logic go, input logic [7:0] data,
                           output hdu_pkg::uart_res_t res);
    logic rx_fin;
    logic tx_fin;
    logic hit;
    rx_fin = 1'b0;
    tx_fin = 1'b0;
    case (m_phase)
      hdu_pkg::PH_RX: begin
        if (m_bit_idx < hdu_pkg::BitIdxData) begin
          // first sample after the start wait, then one per bit period
          if (timer_hit(m_bit_idx == hdu_pkg::BitIdxFirst ? m_start_wait
                                                          : m_bit_period)) begin
            m_shift   = {rx, m_shift[7:1]};
            m_bit_idx = m_bit_idx + 4'd1;
          end
        end else if (m_bit_idx == hdu_pkg::BitIdxData) begin
          // let one full bit pass without a sample
          if (timer_hit(m_bit_period)) m_bit_idx = hdu_pkg::BitIdxStop;
        end else begin
          // stop wait ends on a high line or on the next tick
          hit = timer_hit(m_bit_period);
          if (rx || hit) begin
            m_rx_byte = m_shift;
            rx_fin    = 1'b1;
            m_phase   = hdu_pkg::PH_IDLE;
            m_count   = '0;
            m_bit_idx = '0;
          end
        end
      end
      hdu_pkg::PH_TX: begin
        if (timer_hit(m_bit_period)) begin
          if (m_bit_idx < hdu_pkg::BitIdxData) begin
            m_line    = m_shift[0];
            m_shift   = m_shift >> 1;
            m_bit_idx = m_bit_idx + 4'd1;
          end else if (m_bit_idx == hdu_pkg::BitIdxData) begin
            m_line    = 1'b1;
            m_bit_idx = hdu_pkg::BitIdxStop;
          end else begin
            m_line    = 1'b1;
            tx_fin    = 1'b1;
            m_phase   = hdu_pkg::PH_IDLE;
            m_bit_idx = '0;
          end
        end
      end
      default: begin
        // a low line wins over a send request
        m_phase = hdu_pkg::PH_IDLE;
        m_line  = 1'b1;
        if (!rx) begin
          m_phase   = hdu_pkg::PH_RX;
          m_count   = '0;
          m_bit_idx = '0;
          m_shift   = '0;
        end else if (go) begin
          m_phase   = hdu_pkg::PH_TX;
          m_count   = '0;
          m_bit_idx = '0;
          m_shift   = data;
          m_line    = 1'b0;
        end
      end
    endcase
    res.tx_line  = m_line;
    res.rx_byte  = m_rx_byte;
    res.rx_done  = rx_fin;
    res.tx_done  = tx_fin;
    res.busy_res = (m_phase != hdu_pkg::PH_IDLE);
  endtask

  // Request driver: advance on acceptance, hold the request otherwise.
  always @(negedge clk_i) begin : drive_requests
    logic        v;
    logic [15:0] d;
    v = 1'b0;
    d = '0;
    if (req_taken) begin
      void'(serial_reqs.pop_front());
      if (!quiet) send_gap = pick_gap();
    end
    if (send_gap > 0) begin
      send_gap--;
    end else if (serial_reqs.size() > 0) begin
      v = 1'b1;
      d = serial_reqs[0];
    end
    s_axis_tvalid <= v;
    s_axis_tdata  <= d;
  end

  // Result side ready: one long hold-off when armed, random stalls otherwise.
  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = pick_gap();
      rdy = 1'b0;
    end
    if (!rst_ni) rdy = 1'b0;
    m_axis_tready <= rdy;
  end

  // Sample both handshakes at the rising edge. Check the result first so a
  // stray result cannot match an expectation pushed in the same cycle.
  always @(posedge clk_i) begin : sample_ports
    hdu_pkg::uart_res_t want;
    hdu_pkg::uart_res_t got;
    hdu_pkg::uart_res_t fresh;
    req_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == hdu_pkg::CfgBitPeriod) m_bit_period = cfg_wdata_i;
        else                                     m_start_wait = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx_line  = m_axis_tdata[0];
        got.rx_byte  = m_axis_tdata[8:1];
        got.rx_done  = m_axis_tdata[9];
        got.tx_done  = m_axis_tdata[10];
        got.busy_res = m_axis_tdata[11];
        if (uart_outputs_due.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          want = uart_outputs_due.pop_front();
          if (got.tx_line !== want.tx_line) begin
            $error("tx_line: expected %0d, actual %0d", want.tx_line, got.tx_line);
            error_count++;
          end
          if (got.rx_byte !== want.rx_byte) begin
            $error("rx_byte: expected %h, actual %h", want.rx_byte, got.rx_byte);
            error_count++;
          end
          if (got.rx_done !== want.rx_done) begin
            $error("rx_done: expected %0d, actual %0d", want.rx_done, got.rx_done);
            error_count++;
          end
          if (got.tx_done !== want.tx_done) begin
            $error("tx_done: expected %0d, actual %0d", want.tx_done, got.tx_done);
            error_count++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        uart_step(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[9:2], fresh);
        uart_outputs_due.push_back(fresh);
      end
    end
  end

  initial begin : watchdog
    while (elapsed_cycles < CycleLimit) begin
      @(posedge clk_i);
      elapsed_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Queue one serial clock; hold off while the queue is full.
  task automatic push_req(logic rx, logic go, logic [7:0] data);
    @(posedge clk_i);
    while (serial_reqs.size() >= QueueDepth) @(posedge clk_i);
    serial_reqs.push_back({6'b0, data, go, rx});
    items_pushed++;
  endtask

  // Drive one 8N1 frame onto the receive line, each bit len clocks long.
  task automatic push_rx_frame(logic [7:0] value, int unsigned len, bit stop_high,
                               bit go_noise, bit go_at_start);
    logic [9:0] bits;
    bits = {stop_high, value, 1'b0};
    for (int k = 0; k < 10; k++)
      for (int c = 0; c < len; c++)
        push_req(bits[k], (k == 0 && c == 0 && go_at_start) ||
                 (go_noise && $urandom_range(0, 3) == 0), 8'($urandom));
  endtask

  // Request a send, then keep the line high for the whole outgoing frame.
  // Noise adds send requests that must be ignored while busy.
  task automatic push_tx_frame(logic [7:0] value, int unsigned period, bit go_noise);
    int unsigned span;
    span = 10 * ((period == 0) ? 1 : period);
    push_req(1'b1, 1'b1, value);
    repeat (span)
      push_req(1'b1, go_noise && $urandom_range(0, 3) == 0, 8'($urandom));
  endtask

  task automatic write_cfg(logic addr, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (serial_reqs.size() != 0 || uart_outputs_due.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then idle the line until the transceiver is back in idle.
  task automatic settle();
    wait_drained();
    while (m_phase != hdu_pkg::PH_IDLE) begin
      repeat (16) push_req(1'b1, 1'b0, 8'($urandom));
      wait_drained();
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned bp;
    int unsigned sw;
    int unsigned len;
    int unsigned budget;
    int unsigned r;

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Idle outputs straight after reset, before any register write.
    repeat (8) push_req(1'b1, 1'b0, 8'($urandom));
    settle();

    // Short bit timing, first sample mid-bit.
    write_cfg(hdu_pkg::CfgBitPeriod, 16'd3);
    write_cfg(hdu_pkg::CfgStartWait, 16'd4);
    push_rx_frame(8'h00, 3, 1'b1, 1'b0, 1'b0);
    push_rx_frame(8'hFF, 3, 1'b1, 1'b0, 1'b0);
    push_rx_frame(8'hA5, 3, 1'b1, 1'b1, 1'b0);  // send requests during reception
    push_rx_frame(8'h5A, 3, 1'b0, 1'b0, 1'b0);  // stop bit held low
    settle();
    push_rx_frame(8'h81, 3, 1'b1, 1'b0, 1'b1);  // low line and send request together
    push_tx_frame(8'h00, 3, 1'b0);
    push_tx_frame(8'hFF, 3, 1'b0);
    push_tx_frame(8'h5A, 3, 1'b1);              // send requests while sending
    settle();

    // Minimum timing, then zero timing where every cycle is a tick.
    write_cfg(hdu_pkg::CfgBitPeriod, 16'd1);
    write_cfg(hdu_pkg::CfgStartWait, 16'd1);
    push_rx_frame(8'h33, 1, 1'b1, 1'b0, 1'b0);
    push_tx_frame(8'hCC, 1, 1'b0);
    settle();
    write_cfg(hdu_pkg::CfgBitPeriod, 16'd0);
    write_cfg(hdu_pkg::CfgStartWait, 16'd0);
    push_rx_frame(8'h4B, 1, 1'b1, 1'b0, 1'b0);
    push_tx_frame(8'h69, 0, 1'b0);
    settle();

    // Random frames under several timings. Arm the long hold-off first so
    // the request side backs up while frames keep coming.
    hold_arm = 1'b1;
    repeat (4) begin
      quiet = ($urandom_range(0, 3) == 0);
      bp = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) bp = $urandom_range(5, 10);
      sw = $urandom_range(0, 1) ? bp + bp / 2 : $urandom_range(1, 2 * bp + 2);
      write_cfg(hdu_pkg::CfgBitPeriod, 16'(bp));
      write_cfg(hdu_pkg::CfgStartWait, 16'(sw));
      budget = items_pushed + 50;
      while (items_pushed < budget) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          // mostly well-formed frames, some with bit-length jitter
          len = bp;
          if ($urandom_range(0, 4) == 0) len = $urandom_range((bp > 1) ? bp - 1 : 1, bp + 1);
          push_rx_frame(8'($urandom), len, $urandom_range(0, 9) != 0,
                        $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
          repeat ($urandom_range(0, bp)) push_req(1'b1, 1'b0, 8'($urandom));
        end else if (r < 85) begin
          push_tx_frame(8'($urandom), bp, $urandom_range(0, 4) == 0);
        end else begin
          // noise: short glitches and stray requests
          repeat ($urandom_range(1, 8))
            push_req(1'($urandom), 1'($urandom), 8'($urandom));
        end
      end
      settle();
      quiet = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else                  $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/hdu_pkg.sv
sv/hdu_step.sv
sv/half_duplex_uart_8n1.sv
sim/half_duplex_uart_8n1_test.sv
